FILE: rtl/mse_pkg.sv
`timescale 1ns / 1ps

package mse_pkg;

  // capacity of one set and width of a stored element
  localparam int MaxItems  = 64;
  localparam int DataWidth = 32;

  // buffer address and element count (count reaches MaxItems itself)
  localparam int AddrW = $clog2(MaxItems);
  localparam int CntW  = $clog2(MaxItems + 1);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_START,
    ST_MERGE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last_item;
  } in_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               last_out;
    logic               overflow;
  } out_t;

endpackage

FILE: rtl/merge_sort_engine.sv
`timescale 1ns / 1ps

// merge sort engine: values arrive one per input transaction and are stored
// in buffer a; the transaction flagged last_item closes the set. the set is
// then sorted in ascending order by a stable bottom-up merge sort that
// ping-pongs between two 64-entry buffers, and the values leave one per
// output transaction, the final one flagged by last_out. a set keeps at most
// mse_pkg::MaxItems values; further values are dropped and every output
// transaction of that set carries overflow. input is stalled from the close
// of a set until its last value has been taken. a set of n kept values is
// loaded one value per transaction, then sorted in ceil(log2 n) merge
// passes, each moving one element per cycle through the two read ports of
// the source buffer after a set-up state, so that a pass never reads an
// entry written in the same cycle; a further set-up state then precedes the
// output of the n values, one per output transaction, which the consumer
// can stall. the buffers need no clearing after reset.
module merge_sort_engine (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  mse_pkg::in_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output mse_pkg::out_t out_data_o
);

  localparam int AddrW = mse_pkg::AddrW;
  localparam int CntW  = mse_pkg::CntW;
  localparam int DataW = mse_pkg::DataWidth;

  // the two buffers, one synchronous memory each
  logic [DataW-1:0] mem_a [mse_pkg::MaxItems];
  logic [DataW-1:0] mem_b [mse_pkg::MaxItems];

  mse_pkg::state_e state_q, state_d;

  logic [CntW-1:0] count_q, count_d;   // kept values of the current set
  logic            ovf_q, ovf_d;       // a value of this set was dropped
  logic            src_b_q, src_b_d;   // pass source is buffer b
  logic [CntW-1:0] width_q, width_d;   // run width of the current pass
  logic [CntW-1:0] i_q, i_d;           // head of the left run / output pointer
  logic [CntW-1:0] j_q, j_d;           // head of the right run
  logic [CntW-1:0] k_q, k_d;           // destination slot
  logic [CntW-1:0] mid_q, mid_d;       // end of the left run
  logic [CntW-1:0] hi_q, hi_d;         // end of the right run

  // registered read data, port 0 follows i, port 1 follows j
  logic [DataW-1:0] rd_a0_q, rd_a1_q, rd_b0_q, rd_b1_q;
  logic [DataW-1:0] head_i, head_j;

  // write port controls
  logic             we_a, we_b;
  logic [AddrW-1:0] wa_a, wa_b;
  logic [DataW-1:0] wd_a, wd_b;

  logic in_fire, out_fire, is_last_out, take_i;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;

  assign head_i = src_b_q ? rd_b0_q : rd_a0_q;
  assign head_j = src_b_q ? rd_b1_q : rd_a1_q;

  assign is_last_out = (i_q == count_q - CntW'(1));

  // left head wins while it remains and either the right run is spent or it is not above the right head (stable)
  assign take_i = (i_q < mid_q) &&
                  ((j_q >= hi_q) || ($signed(head_i) <= $signed(head_j)));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mse_pkg::ST_LOAD: begin
        if (in_fire && in_data_i.last_item) state_d = mse_pkg::ST_START;
      end
      mse_pkg::ST_START: begin
        if (width_q < count_q) state_d = mse_pkg::ST_MERGE;
        else                   state_d = mse_pkg::ST_EMIT;
      end
      mse_pkg::ST_MERGE: begin
        if ((k_q + CntW'(1) == hi_q) && (hi_q == count_q)) state_d = mse_pkg::ST_START;
      end
      mse_pkg::ST_EMIT: begin
        if (out_fire && is_last_out) state_d = mse_pkg::ST_LOAD;
      end
      default: state_d = mse_pkg::ST_LOAD;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic [CntW:0] sum_mid;
    logic [CntW:0] sum_hi;
    logic [CntW:0] base;
    logic [CntW-1:0] k_next;

    count_d = count_q;
    ovf_d   = ovf_q;
    src_b_d = src_b_q;
    width_d = width_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    mid_d   = mid_q;
    hi_d    = hi_q;

    we_a = 1'b0;
    wa_a = count_q[AddrW-1:0];
    wd_a = DataW'(unsigned'(in_data_i.value));
    we_b = 1'b0;
    wa_b = k_q[AddrW-1:0];
    wd_b = take_i ? head_i : head_j;

    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;

    base    = '0;
    sum_mid = '0;
    sum_hi  = '0;
    k_next  = k_q + CntW'(1);

    unique case (state_q)
      mse_pkg::ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_fire) begin
          if (count_q < CntW'(mse_pkg::MaxItems)) begin
            we_a    = 1'b1;
            count_d = count_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_data_i.last_item) begin
            width_d = CntW'(1);
            src_b_d = 1'b0;
          end
        end
      end

      mse_pkg::ST_START: begin
        // first run of the pass, or the first output read
        sum_mid = {1'b0, width_q};
        sum_hi  = {width_q, 1'b0};
        i_d     = '0;
        k_d     = '0;
        mid_d   = (sum_mid > {1'b0, count_q}) ? count_q : sum_mid[CntW-1:0];
        hi_d    = (sum_hi > {1'b0, count_q}) ? count_q : sum_hi[CntW-1:0];
        j_d     = mid_d;
      end

      mse_pkg::ST_MERGE: begin
        we_a = src_b_q;
        wa_a = k_q[AddrW-1:0];
        wd_a = take_i ? head_i : head_j;
        we_b = !src_b_q;
        if (k_next == hi_q) begin
          if (hi_q == count_q) begin
            // pass complete
            width_d = {width_q[CntW-2:0], 1'b0};
            src_b_d = !src_b_q;
          end else begin
            // next pair of runs starts at the end of this one
            base    = {1'b0, hi_q};
            sum_mid = base + {1'b0, width_q};
            sum_hi  = base + {width_q, 1'b0};
            i_d     = hi_q;
            k_d     = hi_q;
            mid_d   = (sum_mid > {1'b0, count_q}) ? count_q : sum_mid[CntW-1:0];
            hi_d    = (sum_hi > {1'b0, count_q}) ? count_q : sum_hi[CntW-1:0];
            j_d     = mid_d;
          end
        end else begin
          k_d = k_next;
          if (take_i) i_d = i_q + CntW'(1);
          else        j_d = j_q + CntW'(1);
        end
      end

      mse_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_fire) begin
          if (is_last_out) begin
            count_d = '0;
            ovf_d   = 1'b0;
          end else begin
            i_d = i_q + CntW'(1);
          end
        end
      end

      default: ;
    endcase
  end

  // payload comes straight from the read register, so it holds under stall
  always_comb begin
    out_data_o.sorted_value = 32'($signed(head_i));
    out_data_o.last_out     = is_last_out;
    out_data_o.overflow     = ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mse_pkg::ST_LOAD;
      count_q <= '0;
      ovf_q   <= 1'b0;
      src_b_q <= 1'b0;
      width_q <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      mid_q   <= '0;
      hi_q    <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      src_b_q <= src_b_d;
      width_q <= width_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      mid_q   <= mid_d;
      hi_q    <= hi_d;
    end
  end

  // buffer a: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_a) mem_a[wa_a] <= wd_a;
    rd_a0_q <= mem_a[i_d[AddrW-1:0]];
    rd_a1_q <= mem_a[j_d[AddrW-1:0]];
  end

  // buffer b: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_b) mem_b[wa_b] <= wd_b;
    rd_b0_q <= mem_b[i_d[AddrW-1:0]];
    rd_b1_q <= mem_b[j_d[AddrW-1:0]];
  end

  // no input is taken while results are being delivered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted during output");

  // every slot written so far came from exactly one of the two runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mse_pkg::ST_MERGE) |-> (i_q + j_q == k_q + mid_q))
    else $error("merge heads out of step with destination");

  // a merge never writes past its run or the set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mse_pkg::ST_MERGE) |-> (k_q < hi_q && hi_q <= count_q))
    else $error("merge destination out of range");

  // the set never grows beyond capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(mse_pkg::MaxItems))
    else $error("element count beyond capacity");

  // taking the final result reopens the input for a fresh set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_data_o.last_out) |=> (!in_stall_o && count_q == '0 && !ovf_q))
    else $error("set not closed after final result");

endmodule
